>>> rtl/dcma_pkg.sv
// dcma_pkg: shared constants, beat types and back-end state codes of the
// dual-channel moving average; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dcma_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int VREF_W         = 13;
   localparam int MEAN_W         = 20;
   localparam int UV_W           = 23;
   localparam int MEAN_FRAC      = 8;
   localparam int UV_SCALE       = 1000;
   localparam int UV_SCALE_W     = 10;
   localparam int WINDOW_DEFAULT = 30;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [VREF_W-1:0] VREF_RESET = 13'd3300;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_ch1;
      logic [SAMPLE_BITS-1:0] sample_ch2;
   } req_type;

   typedef struct packed {
      logic [MEAN_W-1:0] mean_ch1;
      logic [MEAN_W-1:0] mean_ch2;
      logic [UV_W-1:0]   microvolts_ch1;
      logic [UV_W-1:0]   microvolts_ch2;
      logic              window_full;
   } rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_MUL  = 3'b010,
      BK_DIV  = 3'b100
   } back_state_type;

endpackage

`default_nettype wire

>>> rtl/dcma_front.sv
// dcma_front: sample rings, running sums and write index; pushes the
// updated sums and sample count into the work queue. uses dcma_pkg
`timescale 1ns / 1ps
`default_nettype none

module dcma_front
   import dcma_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT,
   localparam int IDX_W = $clog2(WINDOW),
   localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW),
   localparam int CNT_W = $clog2(WINDOW + 1),
   localparam int ENT_W = 2 * SUM_W + CNT_W + 1,
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire req_type          req_data,
   output logic                  req_full,
   input  wire logic [LVL_W-1:0] q_level,
   output logic                  q_push,
   output logic [ENT_W-1:0]      q_wdata
);

   logic [SAMPLE_BITS-1:0] ring1 [WINDOW];
   logic [SAMPLE_BITS-1:0] ring2 [WINDOW];

   logic [IDX_W-1:0]       pos_ff, pos_in, wpos_ff;
   logic                   filled_ff, filled_in;
   logic [SUM_W-1:0]       sum1_ff, sum1_in, sum2_ff, sum2_in;
   logic                   v_ff;
   logic [SAMPLE_BITS-1:0] s1_ff, s2_ff, old1_ff, old2_ff;
   logic                   sub_ff, wfull_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   accept, pos_last;
   logic [LVL_W:0]         occupancy;

   // every beat in flight must find a queue slot
   assign occupancy = {1'b0, q_level} + (LVL_W + 1)'(v_ff);
   assign req_full  = occupancy >= (LVL_W + 1)'(QUEUE_DEPTH);
   assign accept    = req_push && !req_full;

   assign pos_last  = pos_ff == IDX_W'(WINDOW - 1);
   assign pos_in    = pos_last ? '0 : pos_ff + 1'b1;
   assign filled_in = filled_ff || pos_last;

   // oldest sample leaves the sum only once the ring has wrapped
   assign sum1_in = sum1_ff + SUM_W'(s1_ff) - (sub_ff ? SUM_W'(old1_ff) : '0);
   assign sum2_in = sum2_ff + SUM_W'(s2_ff) - (sub_ff ? SUM_W'(old2_ff) : '0);

   assign q_push  = v_ff;
   assign q_wdata = {wfull_ff, cnt_ff, sum2_in, sum1_in};

   // read slot of the new beat differs from the slot written by the previous one
   always_ff @(posedge clock) begin
      if (accept) begin
         old1_ff <= ring1[pos_ff];
         old2_ff <= ring2[pos_ff];
      end
      if (v_ff) begin
         ring1[wpos_ff] <= s1_ff;
         ring2[wpos_ff] <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff    <= req_data.sample_ch1;
         s2_ff    <= req_data.sample_ch2;
         wpos_ff  <= pos_ff;
         sub_ff   <= filled_ff;
         wfull_ff <= filled_in;
         cnt_ff   <= filled_ff ? CNT_W'(WINDOW) : CNT_W'(pos_ff) + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= 1'b0;
         pos_ff    <= '0;
         filled_ff <= 1'b0;
         sum1_ff   <= '0;
         sum2_ff   <= '0;
      end else begin
         v_ff <= accept;
         if (accept) begin
            pos_ff    <= pos_in;
            filled_ff <= filled_in;
         end
         if (v_ff) begin
            sum1_ff <= sum1_in;
            sum2_ff <= sum2_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/dcma_queue.sv
// dcma_queue: short flop-based fifo between front and back end
// uses dcma_pkg for its depth
`timescale 1ns / 1ps
`default_nettype none

module dcma_queue
   import dcma_pkg::*;
#(
   parameter int W = 8,
   localparam int PTR_W = $clog2(QUEUE_DEPTH),
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire logic [W-1:0]  wdata,
   input  wire logic          pop,
   output logic [W-1:0]       rdata,
   output logic               empty,
   output logic [LVL_W-1:0]   level
);

   logic [W-1:0]     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [LVL_W-1:0] level_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign rdata = slot_ff[rd_ff];
   assign empty = level_ff == '0;
   assign level = level_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= next_ptr(wr_ff);
         end
         if (pop) begin
            rd_ff <= next_ptr(rd_ff);
         end
         if (push && !pop) begin
            level_ff <= level_ff + 1'b1;
         end else if (pop && !push) begin
            level_ff <= level_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/dcma_div.sv
// dcma_div: restoring divider, one quotient bit per cycle
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module dcma_div #(
   parameter int DVD_W = 28,
   parameter int DVS_W = 5,
   localparam int STEP_W = $clog2(DVD_W + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  busy,
   output logic [DVD_W-1:0]      quotient
);

   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in, dvs_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic [DVS_W:0]    trial;
   logic              fits;

   assign trial    = {rem_ff, quo_ff[DVD_W-1]};
   assign fits     = trial >= {1'b0, dvs_ff};
   // remainder stays below the divisor, so the top bit drops out
   assign rem_in   = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
   assign quo_in   = {quo_ff[DVD_W-2:0], fits};
   assign busy     = busy_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= STEP_W'(DVD_W);
      end else if (busy_ff) begin
         step_ff <= step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/dcma_back.sv
// dcma_back: scales the window sums, divides by the sample count and
// holds the result beat. uses dcma_pkg and dcma_div
`timescale 1ns / 1ps
`default_nettype none

module dcma_back
   import dcma_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT,
   localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW),
   localparam int CNT_W   = $clog2(WINDOW + 1),
   localparam int ENT_W   = 2 * SUM_W + CNT_W + 1,
   localparam int P_W     = SUM_W + VREF_W,
   localparam int PROD_W  = P_W + UV_SCALE_W,
   localparam int UV_DVD  = PROD_W - SAMPLE_BITS,
   localparam int MN_DVD  = SUM_W + MEAN_FRAC,
   localparam int DIV_W   = (UV_DVD > MN_DVD) ? UV_DVD : MN_DVD,
   localparam int LANES   = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [VREF_W-1:0] vref_mv,
   input  wire logic              q_empty,
   input  wire logic [ENT_W-1:0]  q_rdata,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output rsp_type                rsp_data
);

   back_state_type   state_ff, state_in;
   logic [SUM_W-1:0] sum1_ff, sum2_ff, q_sum1, q_sum2;
   logic [CNT_W-1:0] cnt_ff, q_cnt;
   logic             wfull_ff, q_wfull;
   logic [P_W-1:0]   p1_ff, p2_ff;
   logic [PROD_W-1:0] n1, n2;
   logic [DIV_W-1:0] dvd   [LANES];
   logic [DIV_W-1:0] quo   [LANES];
   logic [LANES-1:0] busy;
   logic             start, load;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;

   assign {q_wfull, q_cnt, q_sum2, q_sum1} = q_rdata;

   assign q_pop = (state_ff == BK_IDLE) && !q_empty;
   assign start = state_ff == BK_MUL;
   assign load  = (state_ff == BK_DIV) && (busy == '0) && (!rsp_valid_ff || rsp_pop);

   // sum * vref * 1000, the 2^SAMPLE_BITS divisor is folded in as a shift
   assign n1 = PROD_W'(p1_ff) * PROD_W'(UV_SCALE);
   assign n2 = PROD_W'(p2_ff) * PROD_W'(UV_SCALE);

   assign dvd[0] = DIV_W'({sum1_ff, MEAN_FRAC'(0)});
   assign dvd[1] = DIV_W'({sum2_ff, MEAN_FRAC'(0)});
   assign dvd[2] = DIV_W'(n1[PROD_W-1:SAMPLE_BITS]);
   assign dvd[3] = DIV_W'(n2[PROD_W-1:SAMPLE_BITS]);

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      dcma_div #(
         .DVD_W (DIV_W),
         .DVS_W (CNT_W)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (start),
         .dividend (dvd[i]),
         .divisor  (cnt_ff),
         .busy     (busy[i]),
         .quotient (quo[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            state_in = BK_DIV;
         end
         BK_DIV: begin
            if (load) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         sum1_ff  <= q_sum1;
         sum2_ff  <= q_sum2;
         cnt_ff   <= q_cnt;
         wfull_ff <= q_wfull;
         p1_ff    <= P_W'(q_sum1) * P_W'(vref_mv);
         p2_ff    <= P_W'(q_sum2) * P_W'(vref_mv);
      end
      if (load) begin
         rsp_ff.mean_ch1       <= quo[0][MEAN_W-1:0];
         rsp_ff.mean_ch2       <= quo[1][MEAN_W-1:0];
         rsp_ff.microvolts_ch1 <= quo[2][UV_W-1:0];
         rsp_ff.microvolts_ch2 <= quo[3][UV_W-1:0];
         rsp_ff.window_full    <= wfull_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/dual_channel_moving_average.sv
// dual_channel_moving_average: two-channel boxcar mean with microvolt scaling.
// a taken beat passes the front registers and the work queue; the back end pops
// it, starts the bit-serial dividers (BK_MUL) and loads the result beat once they
// finish and the result register is free, and pops no new beat before that load.
// synchronous reset clears sums, index, fill flag, queue and output; vref = 3300.
`timescale 1ns / 1ps
`default_nettype none

module dual_channel_moving_average
   import dcma_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT,
   localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW),
   localparam int CNT_W = $clog2(WINDOW + 1),
   localparam int ENT_W = 2 * SUM_W + CNT_W + 1,
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire req_type           req_data,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output rsp_type                rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [VREF_W-1:0] csr_data
);

   logic [VREF_W-1:0] vref_ff;
   logic              q_push, q_pop, q_empty;
   logic [ENT_W-1:0]  q_wdata, q_rdata;
   logic [LVL_W-1:0]  q_level;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vref_ff <= VREF_RESET;
      end else if (csr_valid && csr_ready) begin
         vref_ff <= csr_data;
      end
   end

   dcma_front #(.WINDOW (WINDOW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_level  (q_level),
      .q_push   (q_push),
      .q_wdata  (q_wdata)
   );

   dcma_queue #(.W (ENT_W)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty),
      .level (q_level)
   );

   dcma_back #(.WINDOW (WINDOW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .vref_mv   (vref_ff),
      .q_empty   (q_empty),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/dcma_checker.sv
// dcma_checker: port-level checks of the moving average, bound to the top
// level. uses dcma_pkg
`timescale 1ns / 1ps
`default_nettype none

module dcma_checker
   import dcma_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_full,
   input wire logic    rsp_empty,
   input wire logic    rsp_pop,
   input wire rsp_type rsp_data
);

   localparam logic [MEAN_W-1:0] MEAN_MAX = MEAN_W'(((1 << SAMPLE_BITS) - 1) << MEAN_FRAC);

   logic seen_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_full_ff <= 1'b0;
      end else if (!rsp_empty && rsp_data.window_full) begin
         seen_full_ff <= 1'b1;
      end
   end

   // a waiting result beat stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // once the window has filled, every later beat reports it
   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && seen_full_ff |-> rsp_data.window_full)
      else $error("window_full dropped after being set");

   // a mean never exceeds full scale
   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.mean_ch1 <= MEAN_MAX && rsp_data.mean_ch2 <= MEAN_MAX)
      else $error("mean above full scale");

   // after reset nothing is pending and input is open
   a_reset_clear: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("state not cleared by reset");

endmodule

bind dual_channel_moving_average dcma_checker u_dcma_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire
